>>> src/fcsp_pkg.sv
// Shared types, widths and constants of the fan curve / slew / PWM block.
package fcsp_pkg;

  localparam int TEMP_W     = 12;
  localparam int DUTY_W     = 15;
  localparam int RPM_W      = 16;
  localparam int PWM_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 56;

  localparam int PWM_FULL_SCALE = 255;
  localparam int FS_W           = $clog2(PWM_FULL_SCALE + 1);

  localparam int DUTY_FULL  = 25600;
  localparam int DUTY_SHIFT = 10;
  localparam int DUTY_DIV   = DUTY_FULL >> DUTY_SHIFT;

  localparam int MUL_W  = 16;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DVS_W  = 12;

  localparam int CURVE_BITS  = TEMP_W + DUTY_W;
  localparam int PWM_BITS    = DUTY_W + FS_W - DUTY_SHIFT;
  localparam int RPM_BITS    = DUTY_W + RPM_W - DUTY_SHIFT;
  localparam int CURVE_PAIRS = (CURVE_BITS + 1) / 2;
  localparam int PWM_PAIRS   = (PWM_BITS + 1) / 2;
  localparam int RPM_PAIRS   = (RPM_BITS + 1) / 2;
  localparam int DIV_W       = 2 * CURVE_PAIRS;
  localparam int PAIR_W      = $clog2(CURVE_PAIRS + 1);

  localparam logic signed [TEMP_W-1:0] LOW_TEMP_RST  = 12'sd480;
  localparam logic signed [TEMP_W-1:0] HIGH_TEMP_RST = 12'sd1040;
  localparam logic [DUTY_W-1:0]        LOW_DUTY_RST  = 15'd15360;
  localparam logic [DUTY_W-1:0]        HIGH_DUTY_RST = 15'd25600;
  localparam logic [DUTY_W-1:0]        RAMP_STEP_RST = 15'd256;
  localparam logic [RPM_W-1:0]         RPM_FULL_RST  = 16'd1430;
  localparam logic [DUTY_W-1:0]        DUTY_RST      = 15'd15360;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_TEMP  = 3'd0,
    REG_HIGH_TEMP = 3'd1,
    REG_LOW_DUTY  = 3'd2,
    REG_HIGH_DUTY = 3'd3,
    REG_RAMP_STEP = 3'd4,
    REG_RPM_FULL  = 3'd5
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CURVE,
    S_CMUL,
    S_CDIV,
    S_RAMP,
    S_PMUL,
    S_PDIV0,
    S_PDIV,
    S_RMUL,
    S_RDIV0,
    S_RDIV,
    S_OUT
  } fcsp_state_e;

  typedef struct packed {
    logic signed [TEMP_W-1:0] low_temp;
    logic signed [TEMP_W-1:0] high_temp;
    logic [DUTY_W-1:0]        low_duty;
    logic [DUTY_W-1:0]        high_duty;
    logic [DUTY_W-1:0]        ramp_step;
    logic [RPM_W-1:0]         rpm_full;
  } cfg_t;

  typedef struct packed {
    logic              mul_start;
    logic [MUL_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_b;
    logic              div_start;
    logic [DIV_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
    logic [PAIR_W-1:0] pairs;
  } arith_req_t;

  typedef struct packed {
    logic [PROD_W-1:0] product;
    logic [DIV_W-1:0]  quotient;
    logic              div_done;
  } arith_rsp_t;

endpackage

>>> src/fan_curve_slew_pwm.sv
// Top level of the fan curve / slew limit / PWM block.
// Usage:
//   Slave stream: one temperature request per beat. tdata[11:0] holds the
//   signed temperature in 1/16 C, tuser holds its valid flag. A request with
//   the flag low is taken and dropped; it changes no duty state and gives no result.
//   Master stream: one result per valid request, tdata packs pwm_out, current
//   duty, target duty and the RPM estimate.
//   Configuration channel: cfg_index_i selects one of six registers, written
//   on cfg_valid_i; it is always ready. Write only while no request is open.
// Sequencing:
//   A valid request runs through the curve, ramp, PWM and RPM steps; the
//   curve multiply and divide are skipped when the temperature lies at or
//   outside the curve points. tready returns in the same cycle as tvalid,
//   so a request is taken only after the last result is posted. One shared
//   16x16 multiplier and one divider that retires two quotient bits per
//   cycle serve the curve division and both scalings by full duty.
// Reset: registers return to their reset values, duty state to 60 percent.
// Stall: a held result stays in the output register; the next request is
//   still accepted and computed, then waits until the output register frees.
module fan_curve_slew_pwm import fcsp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // [11:0] temperature
  input  logic                  s_axis_tuser,  // [0] temp_valid
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata,  // pwm_out, current_duty, target_duty, rpm_estimate
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t       cfg_q;
  arith_req_t req;
  arith_rsp_t rsp;

  logic [PWM_W-1:0]  pwm;
  logic [DUTY_W-1:0] cur, tgt;
  logic [RPM_W-1:0]  rpm;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_temp  <= LOW_TEMP_RST;
      cfg_q.high_temp <= HIGH_TEMP_RST;
      cfg_q.low_duty  <= LOW_DUTY_RST;
      cfg_q.high_duty <= HIGH_DUTY_RST;
      cfg_q.ramp_step <= RAMP_STEP_RST;
      cfg_q.rpm_full  <= RPM_FULL_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_LOW_TEMP:  cfg_q.low_temp  <= cfg_data_i[TEMP_W-1:0];
        REG_HIGH_TEMP: cfg_q.high_temp <= cfg_data_i[TEMP_W-1:0];
        REG_LOW_DUTY:  cfg_q.low_duty  <= cfg_data_i[DUTY_W-1:0];
        REG_HIGH_DUTY: cfg_q.high_duty <= cfg_data_i[DUTY_W-1:0];
        REG_RAMP_STEP: cfg_q.ramp_step <= cfg_data_i[DUTY_W-1:0];
        REG_RPM_FULL:  cfg_q.rpm_full  <= cfg_data_i[RPM_W-1:0];
        default: ;
      endcase
    end
  end

  fcsp_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .s_valid_i      (s_axis_tvalid),
    .s_ready_o      (s_axis_tready),
    .s_temp_i       (s_axis_tdata[TEMP_W-1:0]),
    .s_temp_valid_i (s_axis_tuser),
    .m_valid_o      (m_axis_tvalid),
    .m_ready_i      (m_axis_tready),
    .pwm_o          (pwm),
    .cur_o          (cur),
    .tgt_o          (tgt),
    .rpm_o          (rpm),
    .req_o          (req),
    .rsp_i          (rsp)
  );

  fcsp_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  assign m_axis_tdata = M_TDATA_W'({rpm, tgt, cur, pwm});

endmodule

>>> src/fcsp_arith.sv
// Shared arithmetic unit: registered multiplier and two-bit-per-cycle restoring divider.
module fcsp_arith import fcsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  arith_req_t req_i,
  output arith_rsp_t rsp_o
);

  logic [PROD_W-1:0] prod_q;
  logic [DVS_W-1:0]  rem_q;
  logic [DIV_W-1:0]  quo_q;
  logic [DVS_W-1:0]  dvs_q;
  logic [PAIR_W-1:0] cnt_q;
  logic              done_q;

  logic [DVS_W:0]    r1, r2;
  logic              ge1, ge2;
  logic [DVS_W-1:0]  r1n, r2n;

  always_comb begin
    r1  = {rem_q, quo_q[DIV_W-1]};
    ge1 = (r1 >= {1'b0, dvs_q});
    r1n = ge1 ? DVS_W'(r1 - {1'b0, dvs_q}) : r1[DVS_W-1:0];
    r2  = {r1n, quo_q[DIV_W-2]};
    ge2 = (r2 >= {1'b0, dvs_q});
    r2n = ge2 ? DVS_W'(r2 - {1'b0, dvs_q}) : r2[DVS_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.mul_start) begin
      prod_q <= req_i.mul_a * req_i.mul_b;
    end
    if (req_i.div_start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (cnt_q != '0) begin
      rem_q <= r2n;
      quo_q <= {quo_q[DIV_W-3:0], ge1, ge2};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= !req_i.div_start && (cnt_q == PAIR_W'(1));
      if (req_i.div_start) begin
        cnt_q <= req_i.pairs;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - PAIR_W'(1);
      end
    end
  end

  assign rsp_o.product  = prod_q;
  assign rsp_o.quotient = quo_q;
  assign rsp_o.div_done = done_q;

  a_no_restart_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.div_start |-> cnt_q == '0)
    else $error("divider restarted while busy");

  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(cnt_q) == PAIR_W'(1))
    else $error("divider done without a final step");

  a_load_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.div_start |=> cnt_q == $past(req_i.pairs))
    else $error("divider step count not loaded");

endmodule

>>> src/fcsp_ctrl.sv
// Sequencer: fan curve, slew limit, duty state and result register.
module fcsp_ctrl import fcsp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  logic                     s_valid_i,
  output logic                     s_ready_o,
  input  logic signed [TEMP_W-1:0] s_temp_i,
  input  logic                     s_temp_valid_i,
  output logic                     m_valid_o,
  input  logic                     m_ready_i,
  output logic [PWM_W-1:0]         pwm_o,
  output logic [DUTY_W-1:0]        cur_o,
  output logic [DUTY_W-1:0]        tgt_o,
  output logic [RPM_W-1:0]         rpm_o,
  output arith_req_t               req_o,
  input  arith_rsp_t               rsp_i
);

  fcsp_state_e state_q, state_d;

  logic signed [TEMP_W-1:0] temp_q;
  logic                     neg_q;
  logic [DUTY_W-1:0]        duty_now_q, duty_now_d;
  logic [DUTY_W-1:0]        duty_goal_q, duty_goal_d;
  logic [PWM_W-1:0]         pwm_q;
  logic [RPM_W-1:0]         rpm_q;
  logic                     m_valid_q;
  logic [PWM_W-1:0]         out_pwm_q;
  logic [DUTY_W-1:0]        out_cur_q, out_tgt_q;
  logic [RPM_W-1:0]         out_rpm_q;

  logic ld_temp, ld_neg, ld_goal, ld_now, ld_pwm, ld_out, out_free;
  logic at_low, at_high;

  logic signed [TEMP_W:0]   t_off, span;
  logic signed [DUTY_W:0]   duty_diff;
  logic [DUTY_W:0]          duty_mag;
  logic                     diff_neg;
  logic [DUTY_W-1:0]        q15, goal_curve;
  logic [DUTY_W:0]          up_sum, dn_val, ramp_val;
  logic [PROD_W-1:0]        scaled;
  logic [MUL_W-1:0]         pwm_wide;

  assign out_free = !m_valid_q || m_ready_i;
  assign at_low   = $signed(temp_q) <= $signed(cfg_i.low_temp);
  assign at_high  = $signed(temp_q) >= $signed(cfg_i.high_temp);

  assign t_off     = $signed({temp_q[TEMP_W-1], temp_q})
                   - $signed({cfg_i.low_temp[TEMP_W-1], cfg_i.low_temp});
  assign span      = $signed({cfg_i.high_temp[TEMP_W-1], cfg_i.high_temp})
                   - $signed({cfg_i.low_temp[TEMP_W-1], cfg_i.low_temp});
  assign duty_diff = $signed({1'b0, cfg_i.high_duty}) - $signed({1'b0, cfg_i.low_duty});
  assign diff_neg  = duty_diff[DUTY_W];
  assign duty_mag  = diff_neg ? (DUTY_W+1)'(-duty_diff) : duty_diff;

  assign q15        = rsp_i.quotient[DUTY_W-1:0];
  assign goal_curve = neg_q ? (cfg_i.low_duty - q15) : (cfg_i.low_duty + q15);
  assign scaled     = rsp_i.product >> DUTY_SHIFT;
  assign pwm_wide   = MUL_W'(PWM_FULL_SCALE) - rsp_i.quotient[MUL_W-1:0];

  always_comb begin
    up_sum = {1'b0, duty_now_q} + {1'b0, cfg_i.ramp_step};
    dn_val = (duty_now_q >= cfg_i.ramp_step) ? {1'b0, duty_now_q - cfg_i.ramp_step} : '0;
    if (duty_now_q < duty_goal_q) begin
      ramp_val = (up_sum > {1'b0, duty_goal_q}) ? {1'b0, duty_goal_q} : up_sum;
    end else if (duty_now_q > duty_goal_q) begin
      ramp_val = (dn_val < {1'b0, duty_goal_q}) ? {1'b0, duty_goal_q} : dn_val;
    end else begin
      ramp_val = {1'b0, duty_now_q};
    end
    if (ramp_val > (DUTY_W+1)'(DUTY_FULL)) begin
      ramp_val = (DUTY_W+1)'(DUTY_FULL);
    end
    duty_now_d = ramp_val[DUTY_W-1:0];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i && s_temp_valid_i) state_d = S_CURVE;
      end
      S_CURVE: begin
        state_d = (at_low || at_high) ? S_RAMP : S_CMUL;
      end
      S_CMUL:  state_d = S_CDIV;
      S_CDIV: begin
        if (rsp_i.div_done) state_d = S_RAMP;
      end
      S_RAMP:  state_d = S_PMUL;
      S_PMUL:  state_d = S_PDIV0;
      S_PDIV0: state_d = S_PDIV;
      S_PDIV: begin
        if (rsp_i.div_done) state_d = S_RMUL;
      end
      S_RMUL:  state_d = S_RDIV0;
      S_RDIV0: state_d = S_RDIV;
      S_RDIV: begin
        if (rsp_i.div_done) state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_ready_o   = (state_q == S_IDLE);
    req_o       = '0;
    ld_temp     = 1'b0;
    ld_neg      = 1'b0;
    ld_goal     = 1'b0;
    ld_now      = 1'b0;
    ld_pwm      = 1'b0;
    ld_out      = 1'b0;
    duty_goal_d = goal_curve;
    case (state_q)
      S_IDLE: ld_temp = s_valid_i;
      S_CURVE: begin
        ld_neg = 1'b1;
        if (at_low) begin
          ld_goal     = 1'b1;
          duty_goal_d = cfg_i.low_duty;
        end else if (at_high) begin
          ld_goal     = 1'b1;
          duty_goal_d = cfg_i.high_duty;
        end else begin
          req_o.mul_start = 1'b1;
          req_o.mul_a     = MUL_W'(t_off[TEMP_W-1:0]);
          req_o.mul_b     = MUL_W'(duty_mag);
        end
      end
      S_CMUL: begin
        req_o.div_start = 1'b1;
        req_o.dividend  = DIV_W'(rsp_i.product) << (DIV_W - 2 * CURVE_PAIRS);
        req_o.divisor   = span[DVS_W-1:0];
        req_o.pairs     = PAIR_W'(CURVE_PAIRS);
      end
      S_CDIV:  ld_goal = rsp_i.div_done;
      S_RAMP:  ld_now  = 1'b1;
      S_PMUL: begin
        req_o.mul_start = 1'b1;
        req_o.mul_a     = MUL_W'(duty_now_q);
        req_o.mul_b     = MUL_W'(PWM_FULL_SCALE);
      end
      S_PDIV0: begin
        req_o.div_start = 1'b1;
        req_o.dividend  = DIV_W'(scaled << (DIV_W - 2 * PWM_PAIRS));
        req_o.divisor   = DVS_W'(DUTY_DIV);
        req_o.pairs     = PAIR_W'(PWM_PAIRS);
      end
      S_PDIV:  ld_pwm = rsp_i.div_done;
      S_RMUL: begin
        req_o.mul_start = 1'b1;
        req_o.mul_a     = MUL_W'(duty_now_q);
        req_o.mul_b     = cfg_i.rpm_full;
      end
      S_RDIV0: begin
        req_o.div_start = 1'b1;
        req_o.dividend  = DIV_W'(scaled << (DIV_W - 2 * RPM_PAIRS));
        req_o.divisor   = DVS_W'(DUTY_DIV);
        req_o.pairs     = PAIR_W'(RPM_PAIRS);
      end
      S_RDIV:  ;
      S_OUT:   ld_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ld_temp) temp_q <= s_temp_i;
    if (ld_neg)  neg_q  <= diff_neg;
    if (ld_pwm)  pwm_q  <= pwm_wide[PWM_W-1:0];
    if (state_q == S_RDIV && rsp_i.div_done) begin
      rpm_q <= rsp_i.quotient[RPM_W-1:0];
    end
    if (ld_out) begin
      out_pwm_q <= pwm_q;
      out_cur_q <= duty_now_q;
      out_tgt_q <= duty_goal_q;
      out_rpm_q <= rpm_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      duty_now_q  <= DUTY_RST;
      duty_goal_q <= DUTY_RST;
      m_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ld_goal) duty_goal_q <= duty_goal_d;
      if (ld_now)  duty_now_q  <= duty_now_d;
      if (ld_out) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_valid_o = m_valid_q;
  assign pwm_o     = out_pwm_q;
  assign cur_o     = out_cur_q;
  assign tgt_o     = out_tgt_q;
  assign rpm_o     = out_rpm_q;

  a_duty_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> out_cur_q <= DUTY_W'(DUTY_FULL))
    else $error("current duty above full scale");

  a_curve_to_ramp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CDIV && rsp_i.div_done) |=> state_q == S_RAMP)
    else $error("curve division did not hand over to the ramp");

  a_result_posted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_free) |=> (m_valid_q && state_q == S_IDLE))
    else $error("result not posted on a free output slot");

endmodule

>>> sim/tb_fan_curve_slew_pwm.sv
// Testbench for the fan curve / slew limit / PWM block: directed and random streams, scoreboarded.
`timescale 1ns / 100ps

module tb_fan_curve_slew_pwm;
  import fcsp_pkg::*;

  localparam int SETTLE_CYCLES = 60;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 95;

  typedef struct {
    logic [PWM_W-1:0]  pwm;
    logic [DUTY_W-1:0] cur_duty;
    logic [DUTY_W-1:0] goal_duty;
    logic [RPM_W-1:0]  rpm;
  } fan_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata;  // [11:0] temperature
  logic                  s_axis_tuser;  // [0] temp_valid
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [M_TDATA_W-1:0]  m_axis_tdata;  // pwm_out, current_duty, target_duty, rpm_estimate
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  fan_result_t pending_results[$];
  int          fail_count;
  bit          quiet_links;
  int          sink_hold_cycles;

  logic signed [TEMP_W-1:0] low_temp_m;
  logic signed [TEMP_W-1:0] high_temp_m;
  logic [DUTY_W-1:0]        low_duty_m;
  logic [DUTY_W-1:0]        high_duty_m;
  logic [DUTY_W-1:0]        ramp_step_m;
  logic [RPM_W-1:0]         rpm_full_m;
  logic [DUTY_W-1:0]        duty_now_m;
  logic [DUTY_W-1:0]        duty_goal_m;

  fan_curve_slew_pwm u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    #(1_500_000 * 20);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_links || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic fan_result_t advance_duty(input logic signed [TEMP_W-1:0] temp);
    fan_result_t r;
    longint      span;
    longint      num;
    longint      goal;
    int unsigned now;
    int unsigned cnt;
    if (temp <= low_temp_m) begin
      duty_goal_m = low_duty_m;
    end else if (temp >= high_temp_m) begin
      duty_goal_m = high_duty_m;
    end else begin
      span = longint'(high_temp_m) - longint'(low_temp_m);
      if (span < 1) span = 1;
      num = (longint'(temp) - longint'(low_temp_m)) *
            (longint'(high_duty_m) - longint'(low_duty_m));
      goal = longint'(low_duty_m) + num / span;
      duty_goal_m = goal[DUTY_W-1:0];
    end
    now = duty_now_m;
    if (now < duty_goal_m) begin
      now += ramp_step_m;
      if (now > duty_goal_m) now = duty_goal_m;
    end else if (now > duty_goal_m) begin
      now = (now >= ramp_step_m) ? now - ramp_step_m : 0;
      if (now < duty_goal_m) now = duty_goal_m;
    end
    if (now > DUTY_FULL) now = DUTY_FULL;
    duty_now_m = now[DUTY_W-1:0];
    cnt = now * PWM_FULL_SCALE / DUTY_FULL;
    r.pwm       = PWM_W'(PWM_FULL_SCALE - cnt);
    r.cur_duty  = duty_now_m;
    r.goal_duty = duty_goal_m;
    r.rpm       = RPM_W'((longint'(now) * longint'(rpm_full_m)) / DUTY_FULL);
    return r;
  endfunction

  task automatic send_sample(input logic signed [TEMP_W-1:0] temp, input logic valid);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_TDATA_W - TEMP_W){1'b0}}, temp};
    s_axis_tuser  <= valid;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (valid) pending_results.push_back(advance_duty(temp));
    @(negedge clk_i);
  endtask

  task automatic wait_results();
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic program_regs(input logic signed [TEMP_W-1:0] lt, input logic signed [TEMP_W-1:0] ht,
                              input logic [DUTY_W-1:0] ld, input logic [DUTY_W-1:0] hd,
                              input logic [DUTY_W-1:0] rs, input logic [RPM_W-1:0] rf);
    cfg_reg_e              order[6];
    logic [CFG_DATA_W-1:0] vals[6];
    order = '{REG_LOW_TEMP, REG_HIGH_TEMP, REG_LOW_DUTY, REG_HIGH_DUTY, REG_RAMP_STEP,
              REG_RPM_FULL};
    vals  = '{{{(CFG_DATA_W - TEMP_W){lt[TEMP_W-1]}}, lt},
              {{(CFG_DATA_W - TEMP_W){ht[TEMP_W-1]}}, ht},
              {1'b0, ld}, {1'b0, hd}, {1'b0, rs}, rf};
    // drain, then let any dropped request finish before touching registers
    s_axis_tvalid <= 1'b0;
    wait_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    for (int i = 0; i < 6; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= order[i];
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      case (order[i])
        REG_LOW_TEMP:  low_temp_m  = vals[i][TEMP_W-1:0];
        REG_HIGH_TEMP: high_temp_m = vals[i][TEMP_W-1:0];
        REG_LOW_DUTY:  low_duty_m  = vals[i][DUTY_W-1:0];
        REG_HIGH_DUTY: high_duty_m = vals[i][DUTY_W-1:0];
        REG_RAMP_STEP: ramp_step_m = vals[i][DUTY_W-1:0];
        REG_RPM_FULL:  rpm_full_m  = vals[i];
        default: ;
      endcase
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [DUTY_W-1:0] pick_duty();
    if ($urandom_range(0, 9) == 0) return DUTY_W'($urandom_range(DUTY_FULL + 1, 32767));
    return DUTY_W'($urandom_range(0, DUTY_FULL));
  endfunction

  function automatic logic signed [TEMP_W-1:0] pick_temp();
    int r;
    int lo;
    int hi;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      lo = (low_temp_m < high_temp_m) ? int'(low_temp_m) : int'(high_temp_m);
      hi = (low_temp_m < high_temp_m) ? int'(high_temp_m) : int'(low_temp_m);
      lo = (lo - 16 < -2048) ? -2048 : lo - 16;
      hi = (hi + 16 > 2047) ? 2047 : hi + 16;
      return TEMP_W'(lo + int'($urandom_range(0, hi - lo)));
    end
    if (r < 80) return TEMP_W'($urandom_range(0, 4095));
    return TEMP_W'(int'($urandom_range(0, 2880)) - 880);
  endfunction

  task automatic test_reset_curve();
    send_sample(12'sd480, 1'b1);
    send_sample(12'sd479, 1'b1);
    send_sample(12'sd1040, 1'b1);
    send_sample(12'sd2047, 1'b1);
    send_sample(12'sd760, 1'b1);
    send_sample(12'sd760, 1'b0);
    send_sample(-12'sd2048, 1'b1);
    send_sample(12'sd1000, 1'b1);
    send_sample(-12'sd1, 1'b0);
  endtask

  task automatic test_corner_configs();
    // falling curve over the whole range, target above full duty
    program_regs(-12'sd2048, 12'sd2047, 15'd32767, 15'd0, 15'd32767, 16'hFFFF);
    send_sample(-12'sd2048, 1'b1);
    send_sample(12'sd0, 1'b1);
    send_sample(12'sd2047, 1'b1);
    send_sample(-12'sd1, 1'b1);
    send_sample(12'sd1, 1'b0);
    send_sample(12'sd1, 1'b1);
    // equal thresholds, zero slew, zero speed
    program_regs(12'sd100, 12'sd100, 15'd0, 15'd25600, 15'd0, 16'd0);
    send_sample(12'sd100, 1'b1);
    send_sample(12'sd101, 1'b1);
    // crossed thresholds
    program_regs(12'sd500, -12'sd500, 15'd1000, 15'd30000, 15'd12800, 16'd1430);
    send_sample(12'sd500, 1'b1);
    send_sample(12'sd0, 1'b1);
    send_sample(12'sd501, 1'b1);
    send_sample(12'sd2000, 1'b1);
  endtask

  task automatic test_backpressure();
    program_regs(LOW_TEMP_RST, HIGH_TEMP_RST, LOW_DUTY_RST, HIGH_DUTY_RST, RAMP_STEP_RST,
                 RPM_FULL_RST);
    quiet_links = 1'b0;
    sink_hold_cycles = 400;
    quiet_links = 1'b1;
    for (int i = 0; i < 12; i++) send_sample(pick_temp(), 1'b1);
    quiet_links = 1'b0;
    s_axis_tvalid <= 1'b0;
    wait_results();
  endtask

  task automatic test_random_traffic();
    logic signed [TEMP_W-1:0] lt;
    logic signed [TEMP_W-1:0] ht;
    logic [DUTY_W-1:0]        rs;
    int                       h;
    int                       r;
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) begin
        program_regs(-12'sd2048, 12'sd2047, 15'd0, 15'd32767, 15'd32767, 16'hFFFF);
      end else if (phase == 1) begin
        program_regs(12'sd2047, -12'sd2048, 15'd32767, 15'd0, 15'd1, 16'd0);
      end else begin
        lt = TEMP_W'($urandom_range(0, 4095));
        if ($urandom_range(0, 9) == 0) begin
          ht = TEMP_W'($urandom_range(0, 4095));
        end else begin
          h = int'(lt) + int'($urandom_range(1, 700));
          ht = TEMP_W'((h > 2047) ? 2047 : h);
        end
        r = $urandom_range(0, 9);
        if (r < 5) rs = DUTY_W'($urandom_range(0, 1024));
        else if (r < 9) rs = DUTY_W'($urandom_range(0, DUTY_FULL));
        else rs = DUTY_W'($urandom_range(0, 32767));
        program_regs(lt, ht, pick_duty(), pick_duty(), rs, RPM_W'($urandom_range(0, 65535)));
      end
      quiet_links = (phase == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 99) < 2) begin
          s_axis_tvalid <= 1'b0;
          wait_results();
        end
        send_sample(pick_temp(), $urandom_range(0, 99) >= 12);
      end
      quiet_links = 1'b0;
    end
  endtask

  initial begin : result_sink
    int stall;
    stall = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold_cycles > 0) begin
        stall = sink_hold_cycles;
        sink_hold_cycles = 0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else if (quiet_links || $urandom_range(0, 99) < 70) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        stall = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    fan_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending: tdata %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[7:0] !== want.pwm) begin
          $error("pwm_out: expected %0d, got %0d", want.pwm, m_axis_tdata[7:0]);
          fail_count++;
        end
        if (m_axis_tdata[22:8] !== want.cur_duty) begin
          $error("current_duty: expected %0d, got %0d", want.cur_duty, m_axis_tdata[22:8]);
          fail_count++;
        end
        if (m_axis_tdata[37:23] !== want.goal_duty) begin
          $error("target_duty: expected %0d, got %0d", want.goal_duty, m_axis_tdata[37:23]);
          fail_count++;
        end
        if (m_axis_tdata[53:38] !== want.rpm) begin
          $error("rpm_estimate: expected %0d, got %0d", want.rpm, m_axis_tdata[53:38]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int guard;
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    s_axis_tvalid    = 1'b0;
    s_axis_tdata     = '0;
    s_axis_tuser     = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = REG_LOW_TEMP;
    cfg_data_i       = '0;
    fail_count       = 0;
    quiet_links      = 1'b0;
    sink_hold_cycles = 0;
    low_temp_m       = LOW_TEMP_RST;
    high_temp_m      = HIGH_TEMP_RST;
    low_duty_m       = LOW_DUTY_RST;
    high_duty_m      = HIGH_DUTY_RST;
    ramp_step_m      = RAMP_STEP_RST;
    rpm_full_m       = RPM_FULL_RST;
    duty_now_m       = DUTY_RST;
    duty_goal_m      = DUTY_RST;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_curve();
    test_corner_configs();
    test_backpressure();
    test_random_traffic();

    s_axis_tvalid <= 1'b0;
    guard = 0;
    do begin
      @(negedge clk_i);
      guard++;
    end while (pending_results.size() != 0 && guard < DRAIN_LIMIT);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      fail_count++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/fcsp_pkg.sv
src/fcsp_arith.sv
src/fcsp_ctrl.sv
src/fan_curve_slew_pwm.sv
sim/tb_fan_curve_slew_pwm.sv
